>>> sv/navmesh_triangle_query_macros.svh
// assertion helpers for the triangle query block
`ifndef NAVMESH_TRIANGLE_QUERY_MACROS_SVH
`define NAVMESH_TRIANGLE_QUERY_MACROS_SVH

`ifndef SYNTHESIS
`define NVQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("nvq check failed");
`define NVQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("nvq check failed");
`else
`define NVQ_ASSERT(label, clk, rst, prop)
`define NVQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> sv/nvq_pkg.sv
package nvq_pkg;

  localparam int COORD_BITS = 20;
  localparam int INDEX_BITS = 16;

  localparam int CW   = COORD_BITS;
  localparam int VW   = 3 * CW;
  localparam int DFW  = CW + 1;
  localparam int PW   = 2 * DFW;
  localparam int NCW  = PW + 1;
  localparam int DW   = NCW;
  localparam int HPW  = NCW + DFW;
  localparam int NW   = HPW + 1;
  localparam int QB   = CW + 1;
  localparam int NBW  = INDEX_BITS + 1;
  localparam int SW   = CW + 2;
  localparam int FB_K = ((CW + 3) % 2 == 1) ? CW + 3 : CW + 4;
  localparam logic [FB_K-1:0] FB_RECIP = FB_K'(((64'd1 << FB_K) + 64'd1) / 64'd3);

  localparam int CFG_IDX_W  = 3;
  localparam int FIFO_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_AB = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_BC = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_CA = 3'd5;

  localparam logic [1:0] EDGE_AB   = 2'd0;
  localparam logic [1:0] EDGE_BC   = 2'd1;
  localparam logic [1:0] EDGE_CA   = 2'd2;
  localparam logic [1:0] EDGE_NONE = 2'd3;

  localparam logic [NBW-1:0] NO_CELL = NBW'(1) << INDEX_BITS;

  localparam logic signed [CW-1:0] H_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] H_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [DFW-1:0] diff_t;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_z;
  } query_t;

  typedef struct packed {
    logic                 inside_res;
    logic [1:0]           exit_edge;
    logic [NBW-1:0]       exit_neighbor;
    logic signed [CW-1:0] height;
    logic                 height_fallback;
  } result_t;

  // triangle constants derived from the configuration
  typedef struct packed {
    coord_t                ax;
    coord_t                az;
    coord_t                bx;
    coord_t                bz;
    coord_t                cx;
    coord_t                cz;
    coord_t                ay;
    diff_t                 ab_dx;
    diff_t                 ab_dz;
    diff_t                 bc_dx;
    diff_t                 bc_dz;
    diff_t                 ca_dx;
    diff_t                 ca_dz;
    logic signed [NCW-1:0] nx;
    logic signed [NCW-1:0] nz;
    logic [DW-1:0]         d_mag;
    logic                  ny_neg;
    logic                  ny_zero;
    coord_t                fb_height;
    logic [NBW-1:0]        nb_ab;
    logic [NBW-1:0]        nb_bc;
    logic [NBW-1:0]        nb_ca;
  } tri_t;

  // classified item handed from front to back
  typedef struct packed {
    logic           in_tri;
    logic [1:0]     edge_code;
    logic [NBW-1:0] nb;
    logic [NW-1:0]  num_mag;
    logic           num_neg;
  } work_t;

  // one divider stage
  typedef struct packed {
    logic           in_tri;
    logic [1:0]     edge_code;
    logic [NBW-1:0] nb;
    logic           neg;
    logic           sat;
    logic [NW-1:0]  rem;
    logic [QB-1:0]  quo;
  } div_t;

  function automatic diff_t sdiff(coord_t a, coord_t b);
    return DFW'(a) - DFW'(b);
  endfunction

endpackage

>>> sv/nvq_setup.sv
module nvq_setup (
  input  logic                     clk,
  input  logic [nvq_pkg::VW-1:0]   vertex_a,
  input  logic [nvq_pkg::VW-1:0]   vertex_b,
  input  logic [nvq_pkg::VW-1:0]   vertex_c,
  input  logic [nvq_pkg::NBW-1:0]  neighbor_ab,
  input  logic [nvq_pkg::NBW-1:0]  neighbor_bc,
  input  logic [nvq_pkg::NBW-1:0]  neighbor_ca,
  output nvq_pkg::tri_t            tri_cfg
);
  import nvq_pkg::*;

  coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  diff_t ux, uy, uz, vx, vy, vz;
  diff_t ab_dx, ab_dz, bc_dx, bc_dz, ca_dx, ca_dz;
  logic signed [SW-1:0] ysum;
  logic [SW:0] fb_m;
  logic signed [PW-1:0] p_uyvz, p_uzvy, p_uzvx, p_uxvz, p_uxvy, p_uyvx;
  logic s_neg;
  logic [SW+FB_K:0] fb_prod;
  logic signed [NCW-1:0] nx, nz, ny, ny_w;
  logic [DW-1:0] d_mag;
  logic ny_zero;
  logic [CW-1:0] fbq;
  coord_t fb_height;

  assign ax = vertex_a[3*CW-1:2*CW];
  assign ay = vertex_a[2*CW-1:CW];
  assign az = vertex_a[CW-1:0];
  assign bx = vertex_b[3*CW-1:2*CW];
  assign by = vertex_b[2*CW-1:CW];
  assign bz = vertex_b[CW-1:0];
  assign cx = vertex_c[3*CW-1:2*CW];
  assign cy = vertex_c[2*CW-1:CW];
  assign cz = vertex_c[CW-1:0];

  // first stage: edge vectors and height sum
  always_ff @(posedge clk) begin
    ux    <= sdiff(bx, ax);
    uy    <= sdiff(by, ay);
    uz    <= sdiff(bz, az);
    vx    <= sdiff(cx, ax);
    vy    <= sdiff(cy, ay);
    vz    <= sdiff(cz, az);
    ab_dx <= sdiff(bx, ax);
    ab_dz <= sdiff(bz, az);
    bc_dx <= sdiff(cx, bx);
    bc_dz <= sdiff(cz, bz);
    ca_dx <= sdiff(ax, cx);
    ca_dz <= sdiff(az, cz);
    ysum  <= SW'(ay) + SW'(by) + SW'(cy);
  end

  // magnitude plus one, for rounding the divide by three
  assign fb_m = ysum[SW-1] ? (SW+1)'(-ysum) + (SW+1)'(1) : (SW+1)'(ysum) + (SW+1)'(1);

  // second stage: cross product terms, reciprocal multiply
  always_ff @(posedge clk) begin
    p_uyvz  <= uy * vz;
    p_uzvy  <= uz * vy;
    p_uzvx  <= uz * vx;
    p_uxvz  <= ux * vz;
    p_uxvy  <= ux * vy;
    p_uyvx  <= uy * vx;
    s_neg   <= ysum[SW-1];
    fb_prod <= fb_m * FB_RECIP;
  end

  assign ny_w = NCW'(p_uzvx) - NCW'(p_uxvz);
  assign fbq  = fb_prod[FB_K +: CW];

  // third stage: plane normal and fallback height
  always_ff @(posedge clk) begin
    nx        <= NCW'(p_uyvz) - NCW'(p_uzvy);
    nz        <= NCW'(p_uxvy) - NCW'(p_uyvx);
    ny        <= ny_w;
    d_mag     <= ny_w[NCW-1] ? DW'(-ny_w) : DW'(ny_w);
    ny_zero   <= (ny_w == '0);
    fb_height <= s_neg ? coord_t'(-fbq) : coord_t'(fbq);
  end

  always_comb begin
    tri_cfg           = '0;
    tri_cfg.ax        = ax;
    tri_cfg.az        = az;
    tri_cfg.bx        = bx;
    tri_cfg.bz        = bz;
    tri_cfg.cx        = cx;
    tri_cfg.cz        = cz;
    tri_cfg.ay        = ay;
    tri_cfg.ab_dx     = ab_dx;
    tri_cfg.ab_dz     = ab_dz;
    tri_cfg.bc_dx     = bc_dx;
    tri_cfg.bc_dz     = bc_dz;
    tri_cfg.ca_dx     = ca_dx;
    tri_cfg.ca_dz     = ca_dz;
    tri_cfg.nx        = nx;
    tri_cfg.nz        = nz;
    tri_cfg.d_mag     = d_mag;
    tri_cfg.ny_neg    = ny[NCW-1];
    tri_cfg.ny_zero   = ny_zero;
    tri_cfg.fb_height = fb_height;
    tri_cfg.nb_ab     = neighbor_ab;
    tri_cfg.nb_bc     = neighbor_bc;
    tri_cfg.nb_ca     = neighbor_ca;
  end

endmodule

>>> sv/nvq_front.sv
module nvq_front (
  input  logic            clk,
  input  logic            rst,
  input  nvq_pkg::tri_t   tri_cfg,
  input  logic            take,
  input  nvq_pkg::query_t query,
  output logic            open,
  input  logic            q_full,
  output logic            push,
  output nvq_pkg::work_t  work
);
  import nvq_pkg::*;

  logic v1, v2;
  coord_t x, z;
  logic signed [PW-1:0] ab_pa, ab_pb, bc_pa, bc_pb, ca_pa, ca_pb;
  logic signed [HPW-1:0] hp_x, hp_z;
  logic signed [PW:0] dot_ab, dot_bc, dot_ca;
  logic f_ab, f_bc, f_ca;
  logic signed [NW-1:0] hsum;
  diff_t xa, za, xb, zb, xc, zc;

  assign open = !v2 || !q_full;
  assign push = v2 && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (open) begin
      v1 <= take;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (open) begin
      x <= query.pos_x;
      z <= query.pos_z;
    end
  end

  assign xa = sdiff(x, tri_cfg.ax);
  assign za = sdiff(z, tri_cfg.az);
  assign xb = sdiff(x, tri_cfg.bx);
  assign zb = sdiff(z, tri_cfg.bz);
  assign xc = sdiff(x, tri_cfg.cx);
  assign zc = sdiff(z, tri_cfg.cz);

  // products of the edge tests and the plane numerator
  always_ff @(posedge clk) begin
    if (open) begin
      ab_pa <= tri_cfg.ab_dz * xa;
      ab_pb <= tri_cfg.ab_dx * za;
      bc_pa <= tri_cfg.bc_dz * xb;
      bc_pb <= tri_cfg.bc_dx * zb;
      ca_pa <= tri_cfg.ca_dz * xc;
      ca_pb <= tri_cfg.ca_dx * zc;
      hp_x  <= tri_cfg.nx * xa;
      hp_z  <= tri_cfg.nz * za;
    end
  end

  assign dot_ab = (PW+1)'(ab_pb) - (PW+1)'(ab_pa);
  assign dot_bc = (PW+1)'(bc_pb) - (PW+1)'(bc_pa);
  assign dot_ca = (PW+1)'(ca_pb) - (PW+1)'(ca_pa);
  assign f_ab   = !dot_ab[PW] && (dot_ab != '0);
  assign f_bc   = !dot_bc[PW] && (dot_bc != '0);
  assign f_ca   = !dot_ca[PW] && (dot_ca != '0);
  assign hsum   = NW'(hp_x) + NW'(hp_z);

  always_comb begin
    work        = '0;
    work.in_tri = !(f_ab || f_bc || f_ca);
    if (f_ab) begin
      work.edge_code = EDGE_AB;
      work.nb        = tri_cfg.nb_ab;
    end else if (f_bc) begin
      work.edge_code = EDGE_BC;
      work.nb        = tri_cfg.nb_bc;
    end else if (f_ca) begin
      work.edge_code = EDGE_CA;
      work.nb        = tri_cfg.nb_ca;
    end else begin
      work.edge_code = EDGE_NONE;
      work.nb        = NO_CELL;
    end
    // numerator is the negated sum
    work.num_neg = !hsum[NW-1] && (hsum != '0);
    work.num_mag = hsum[NW-1] ? NW'(-hsum) : NW'(hsum);
  end

endmodule

>>> sv/nvq_fifo.sv
module nvq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> sv/nvq_back.sv
module nvq_back (
  input  logic             clk,
  input  logic             rst,
  input  nvq_pkg::tri_t    tri_cfg,
  input  logic             q_empty,
  input  nvq_pkg::work_t   head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output nvq_pkg::result_t out_data
);
  import nvq_pkg::*;

  logic adv;
  logic vld [QB+1];
  div_t st [QB+1];
  logic [QB:0] qr;
  logic rnd;
  logic signed [CW+2:0] hw;
  coord_t h_div;

  assign adv = !out_valid || out_ready;
  assign pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= pop;
    end
  end

  // entry: quotient range check, anything from 2^QB up saturates
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].in_tri    <= head.in_tri;
      st[0].edge_code <= head.edge_code;
      st[0].nb        <= head.nb;
      st[0].neg       <= head.num_neg ^ tri_cfg.ny_neg;
      st[0].sat       <= ({1'b0, head.num_mag} >= ((NW+1)'(tri_cfg.d_mag) << QB));
      st[0].rem       <= head.num_mag;
      st[0].quo       <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int SH = QB - 1 - k;
    logic [NW-1:0] dsh;
    logic ge;
    div_t st_nxt;
    assign dsh = NW'(tri_cfg.d_mag) << SH;
    assign ge  = (st[k].rem >= dsh);

    always_comb begin
      st_nxt         = st[k];
      st_nxt.rem     = ge ? st[k].rem - dsh : st[k].rem;
      st_nxt.quo[SH] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1] <= st_nxt;
      end
    end
  end

  // round half up on the magnitude, apply sign, add base height
  assign rnd = ({st[QB].rem[DW-1:0], 1'b0} >= {1'b0, tri_cfg.d_mag});
  assign qr  = (QB+1)'(st[QB].quo) + (QB+1)'(rnd);
  assign hw  = st[QB].neg ? (CW+3)'(tri_cfg.ay) - (CW+3)'(qr)
                          : (CW+3)'(tri_cfg.ay) + (CW+3)'(qr);

  always_comb begin
    if (st[QB].sat) begin
      h_div = st[QB].neg ? H_MIN : H_MAX;
    end else if (hw > (CW+3)'(H_MAX)) begin
      h_div = H_MAX;
    end else if (hw < (CW+3)'(H_MIN)) begin
      h_div = H_MIN;
    end else begin
      h_div = hw[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.inside_res      <= st[QB].in_tri;
      out_data.exit_edge       <= st[QB].edge_code;
      out_data.exit_neighbor   <= st[QB].nb;
      out_data.height          <= tri_cfg.ny_zero ? tri_cfg.fb_height : h_div;
      out_data.height_fallback <= tri_cfg.ny_zero;
    end
  end

endmodule

>>> sv/navmesh_triangle_query.sv
// channel | signals                          | transaction when
// in      | in_valid, in_ready, in_data      | in_valid & in_ready
// out     | out_valid, out_ready, out_data   | out_valid & out_ready
// cfg     | cfg_valid, cfg_ready, cfg_index, | cfg_valid & cfg_ready
//         | cfg_data                         |
// one query per cycle sustained while the output is taken; a query passes the
// front registers, the queue and the divider stages of the back pipeline
// the back pipeline advances whenever the output register is empty or taken
// after reset and after every register write in_ready stays low while the
// triangle constants settle through the setup stages
// reset is synchronous and clears control state and the configuration registers only
module navmesh_triangle_query (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  nvq_pkg::query_t                   in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output nvq_pkg::result_t                  out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nvq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nvq_pkg::VW-1:0]            cfg_data
);
  import nvq_pkg::*;
  `include "navmesh_triangle_query_macros.svh"

  localparam logic [1:0] SETTLE = 2'd3;

  // configuration registers
  logic [VW-1:0]  vertex_a, vertex_b, vertex_c;
  logic [NBW-1:0] neighbor_ab, neighbor_bc, neighbor_ca;
  logic [1:0]     settle;
  logic           cfg_wr;

  tri_t  tri_cfg;
  logic  front_open, push, pop, q_full, q_empty;
  work_t work, head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a    <= '0;
      vertex_b    <= '0;
      vertex_c    <= '0;
      neighbor_ab <= NO_CELL;
      neighbor_bc <= NO_CELL;
      neighbor_ca <= NO_CELL;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_VERTEX_A:    vertex_a    <= cfg_data;
        REG_VERTEX_B:    vertex_b    <= cfg_data;
        REG_VERTEX_C:    vertex_c    <= cfg_data;
        REG_NEIGHBOR_AB: neighbor_ab <= cfg_data[NBW-1:0];
        REG_NEIGHBOR_BC: neighbor_bc <= cfg_data[NBW-1:0];
        REG_NEIGHBOR_CA: neighbor_ca <= cfg_data[NBW-1:0];
        default: ;
      endcase
    end
  end

  // hold off queries until the derived constants are current
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      settle <= SETTLE;
    end else if (settle != '0) begin
      settle <= settle - 2'd1;
    end
  end

  assign in_ready = front_open && (settle == '0);

  nvq_setup u_setup (
    .clk         (clk),
    .vertex_a    (vertex_a),
    .vertex_b    (vertex_b),
    .vertex_c    (vertex_c),
    .neighbor_ab (neighbor_ab),
    .neighbor_bc (neighbor_bc),
    .neighbor_ca (neighbor_ca),
    .tri_cfg     (tri_cfg)
  );

  // front: edge tests and plane numerator
  nvq_front u_front (
    .clk     (clk),
    .rst     (rst),
    .tri_cfg (tri_cfg),
    .take    (in_valid && in_ready),
    .query   (in_data),
    .open    (front_open),
    .q_full  (q_full),
    .push    (push),
    .work    (work)
  );

  // queue decouples classification from the divider
  nvq_fifo #(
    .WIDTH ($bits(work_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (work),
    .pop   (pop),
    .rdata (head),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: plane height divide and result register
  nvq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tri_cfg   (tri_cfg),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `NVQ_ASSERT(a_cfg_blocks_in, clk, rst, cfg_wr |=> !in_ready)
  `NVQ_ASSERT(a_inside_no_exit, clk, rst, (out_valid && out_data.inside_res) |-> (out_data.exit_edge == EDGE_NONE && out_data.exit_neighbor == NO_CELL))
  `NVQ_ASSERT(a_outside_has_edge, clk, rst, (out_valid && !out_data.inside_res) |-> (out_data.exit_edge != EDGE_NONE))
  `NVQ_ASSERT_ALWAYS(a_reset_settles, clk, rst |=> !in_ready)

endmodule

>>> verif/tb_top.sv
module tb_top;
  import nvq_pkg::*;

  // spare codes of the register index space, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam longint QUO_CAP  = 64'd1 << 50;

  // triangle shapes used by the random phases
  typedef enum int {SHAPE_NEAR, SHAPE_WIDE, SHAPE_FLAT, SHAPE_EXTREME} shape_e;

  typedef struct {
    query_t  q;
    bit      typed;
    result_t r;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  query_t               in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  result_t              out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VW-1:0]        cfg_data = '0;

  // local copy of the triangle registers
  logic [VW-1:0]  tri_vtx [3];
  logic [NBW-1:0] tri_nb  [3];

  result_t pending_results [$];
  int      errors = 0;
  int      hold_cycles = 0;   // long receiver hold-off, consumed by the receiver
  bit      burst_mode = 1'b0; // no idling on either side while set

  navmesh_triangle_query u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint coord_of(logic [VW-1:0] v, int slot);
    coord_t c;
    c = v[slot*CW +: CW];
    return longint'(c);
  endfunction

  // outward normal test of edge p->q, a zero dot product stays inside
  function automatic bit edge_fails(longint px, longint pz, longint qx, longint qz,
                                    longint x, longint z);
    longint dot;
    dot = -(qz - pz) * (x - px) + (qx - px) * (z - pz);
    return dot > 0;
  endfunction

  function automatic result_t predict_query(query_t q);
    longint x, z, ax, ay, az, bx, by, bz, cx, cy, cz;
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz, s, h, mq;
    logic signed [127:0] t1, t2, t3, t4, num;
    logic [127:0] nmag, dmag, quo, rem;
    result_t r;
    x = longint'(q.pos_x);
    z = longint'(q.pos_z);
    ax = coord_of(tri_vtx[0], 2); ay = coord_of(tri_vtx[0], 1); az = coord_of(tri_vtx[0], 0);
    bx = coord_of(tri_vtx[1], 2); by = coord_of(tri_vtx[1], 1); bz = coord_of(tri_vtx[1], 0);
    cx = coord_of(tri_vtx[2], 2); cy = coord_of(tri_vtx[2], 1); cz = coord_of(tri_vtx[2], 0);
    ux = bx - ax; uy = by - ay; uz = bz - az;
    vx = cx - ax; vy = cy - ay; vz = cz - az;
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    r = '0;
    r.exit_edge = EDGE_NONE;
    r.exit_neighbor = NO_CELL;
    if (edge_fails(ax, az, bx, bz, x, z)) begin
      r.exit_edge = EDGE_AB;
      r.exit_neighbor = tri_nb[0];
    end else if (edge_fails(bx, bz, cx, cz, x, z)) begin
      r.exit_edge = EDGE_BC;
      r.exit_neighbor = tri_nb[1];
    end else if (edge_fails(cx, cz, ax, az, x, z)) begin
      r.exit_edge = EDGE_CA;
      r.exit_neighbor = tri_nb[2];
    end
    r.inside_res = (r.exit_edge == EDGE_NONE);
    if (ny == 0) begin
      // plane is vertical in y, average the vertex heights
      s = ay + by + cy;
      mq = ((s < 0 ? -s : s) + 1) / 3;
      h = s < 0 ? -mq : mq;
      r.height_fallback = 1'b1;
    end else begin
      t1 = nx; t2 = x - ax; t3 = nz; t4 = z - az;
      num = -(t1 * t2 + t3 * t4);
      nmag = num < 0 ? -num : num;
      dmag = ny < 0 ? -ny : ny;
      quo = nmag / dmag;
      rem = nmag % dmag;
      // round half away from zero on the magnitude, capped quotient is not rounded
      if (quo >= QUO_CAP) mq = QUO_CAP;
      else mq = longint'(quo) + ((2 * rem >= dmag) ? 1 : 0);
      h = ay + (((num < 0) != (ny < 0)) ? -mq : mq);
    end
    if (h < longint'(H_MIN)) h = longint'(H_MIN);
    if (h > longint'(H_MAX)) h = longint'(H_MAX);
    r.height = coord_t'(h);
    return r;
  endfunction

  // register write, only called while nothing is in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= REG_VERTEX_C) tri_vtx[idx[1:0]] = data;
    else if (idx <= REG_NEIGHBOR_CA) tri_nb[2'(idx - REG_NEIGHBOR_AB)] = data[NBW-1:0];
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // one query transaction; valid stays high afterwards until the next gap
  task automatic send_query(query_t q, bit typed, result_t r);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(typed ? r : predict_query(q));
  endtask

  function automatic coord_t near_coord(coord_t base, int span);
    return coord_t'(longint'(base) + longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 3))
      0: return H_MIN;
      1: return H_MAX;
      2: return '0;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [VW-1:0] neighbor_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return VW'(NO_CELL);
      2: return {VW{1'b1}};
      default: return VW'({$urandom, $urandom});
    endcase
  endfunction

  // random triangle of the given shape, written through the register port
  task automatic load_triangle(shape_e shape, output coord_t cx, output coord_t cz,
                               output int span);
    coord_t vx [3], vy [3], vz [3];
    int i;
    span = 1 << $urandom_range(2, 12);
    cx = coord_t'($urandom);
    cz = coord_t'($urandom);
    for (i = 0; i < 3; i++) begin
      vx[i] = near_coord(cx, span);
      vz[i] = near_coord(cz, span);
      vy[i] = coord_t'($urandom);
      if (shape == SHAPE_WIDE) begin
        vx[i] = coord_t'($urandom);
        vz[i] = coord_t'($urandom);
      end else if (shape == SHAPE_EXTREME) begin
        vx[i] = extreme_coord();
        vy[i] = extreme_coord();
        vz[i] = extreme_coord();
      end
    end
    if (shape == SHAPE_FLAT) begin
      // collinear in x-z, so the y normal vanishes
      vx[2] = vx[1] + (vx[1] - vx[0]);
      vz[2] = vz[1] + (vz[1] - vz[0]);
    end
    if (shape == SHAPE_WIDE || shape == SHAPE_EXTREME) span = 1 << 19;
    for (i = 0; i < 3; i++) begin
      write_reg(REG_VERTEX_A + CFG_IDX_W'(i), {vx[i], vy[i], vz[i]});
    end
    write_reg(REG_NEIGHBOR_AB, neighbor_value());
    write_reg(REG_NEIGHBOR_BC, neighbor_value());
    write_reg(REG_NEIGHBOR_CA, neighbor_value());
    if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE_HI, VW'({$urandom, $urandom}));
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    int stall, n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      stall = burst_mode ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_data);
        errors++;
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (out_data.inside_res !== e.inside_res) begin
          $display("%0t: inside_res exp %0d got %0d", $realtime, e.inside_res,
                   out_data.inside_res);
          errors++;
        end
        if (out_data.exit_edge !== e.exit_edge) begin
          $display("%0t: exit_edge exp %0d got %0d", $realtime, e.exit_edge,
                   out_data.exit_edge);
          errors++;
        end
        if (out_data.exit_neighbor !== e.exit_neighbor) begin
          $display("%0t: exit_neighbor exp %0h got %0h", $realtime, e.exit_neighbor,
                   out_data.exit_neighbor);
          errors++;
        end
        if (out_data.height !== e.height) begin
          $display("%0t: height exp %0d got %0d", $realtime, e.height, out_data.height);
          errors++;
        end
        if (out_data.height_fallback !== e.height_fallback) begin
          $display("%0t: height_fallback exp %0d got %0d", $realtime, e.height_fallback,
                   out_data.height_fallback);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    result_t   empty_tri;
    coord_t    cx, cz;
    int        span, i, p, n_typed;
    shape_e    shape;
    query_t    q;

    tri_vtx = '{default: '0};
    tri_nb  = '{default: NO_CELL};

    // zero triangle after reset: every point is on it, height falls back to zero
    empty_tri = '{inside_res: 1'b1, exit_edge: EDGE_NONE, exit_neighbor: NO_CELL,
                  height: '0, height_fallback: 1'b1};
    rows.push_back('{'{pos_x: '0, pos_z: '0}, 1'b1, empty_tri});
    rows.push_back('{'{pos_x: H_MAX, pos_z: H_MAX}, 1'b1, empty_tri});
    rows.push_back('{'{pos_x: H_MIN, pos_z: H_MIN}, 1'b1, empty_tri});
    rows.push_back('{'{pos_x: H_MAX, pos_z: H_MIN}, 1'b1, empty_tri});
    rows.push_back('{'{pos_x: H_MIN, pos_z: H_MAX}, 1'b1, empty_tri});
    n_typed = rows.size();
    // directed triangle A(0,0) B(4096,0) C(0,4096): vertices, edges, inside, each side
    rows.push_back('{'{pos_x: 20'sd0,    pos_z: 20'sd0},    1'b0, '0});
    rows.push_back('{'{pos_x: 20'sd4096, pos_z: 20'sd0},    1'b0, '0});
    rows.push_back('{'{pos_x: 20'sd0,    pos_z: 20'sd4096}, 1'b0, '0});
    rows.push_back('{'{pos_x: 20'sd2048, pos_z: 20'sd2048}, 1'b0, '0});
    rows.push_back('{'{pos_x: 20'sd1000, pos_z: 20'sd1000}, 1'b0, '0});
    rows.push_back('{'{pos_x: 20'sd1000, pos_z: -20'sd5},   1'b0, '0});
    rows.push_back('{'{pos_x: 20'sd3000, pos_z: 20'sd3000}, 1'b0, '0});
    rows.push_back('{'{pos_x: -20'sd7,   pos_z: 20'sd1000}, 1'b0, '0});
    rows.push_back('{'{pos_x: H_MAX,     pos_z: H_MAX},     1'b0, '0});
    rows.push_back('{'{pos_x: H_MIN,     pos_z: H_MIN},     1'b0, '0});
    rows.push_back('{'{pos_x: H_MIN,     pos_z: H_MAX},     1'b0, '0});
    rows.push_back('{'{pos_x: H_MAX,     pos_z: H_MIN},     1'b0, '0});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < rows.size(); i++) begin
      if (i == n_typed) begin
        wait_idle();
        // sloped plane with distinct heights; spare index writes must not land
        write_reg(REG_VERTEX_A, {20'sd0,    20'sd256,  20'sd0});
        write_reg(REG_VERTEX_B, {20'sd4096, -20'sd512, 20'sd0});
        write_reg(REG_VERTEX_C, {20'sd0,    20'sd1000, 20'sd4096});
        write_reg(REG_NEIGHBOR_AB, 60'd0);
        write_reg(REG_NEIGHBOR_BC, 60'd65535);
        write_reg(REG_NEIGHBOR_CA, {VW{1'b1}});
        write_reg(REG_SPARE_LO, {VW{1'b1}});
      end
      row = rows[i];
      send_query(row.q, row.typed, row.r);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      shape = shape_e'(p % 4);
      load_triangle(shape, cx, cz, span);
      burst_mode = (p % 5 == 3);
      // long output stall while queries keep coming, the input must back up
      if (p == 1 || p == 7) hold_cycles = 200;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          q.pos_x = near_coord(cx, span + span / 2);
          q.pos_z = near_coord(cz, span + span / 2);
        end else begin
          q.pos_x = coord_t'($urandom);
          q.pos_z = coord_t'($urandom);
        end
        send_query(q, 1'b0, '0);
      end
      burst_mode = 1'b0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
